// ===== hw/rtl/bbp_pkg.sv =====
// Shared types, working widths and the arctangent table of the bearing CORDIC.
package bbp_pkg;

    localparam int WORK_W     = 64;
    localparam int WORK_SHIFT = 60;
    localparam int ACC_W      = 32;
    localparam int ATAN_DEPTH = 32;

    typedef logic signed [WORK_W-1:0] t_work;
    typedef logic [ACC_W-1:0]         t_acc;

    typedef struct packed {
        logic valid;
        logic zero;
    } t_ctl;

    localparam t_acc HALF_TURN = 32'h8000_0000;

    localparam t_acc ATAN_TURNS [ATAN_DEPTH] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

endpackage

// ===== hw/rtl/bbp_prep.sv =====
// Front end: coordinate differences, scaling and the half-turn pre-rotation.
module bbp_prep #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic signed [COORD_WIDTH-1:0] i_start_x,
    input  logic signed [COORD_WIDTH-1:0] i_start_y,
    input  logic signed [COORD_WIDTH-1:0] i_stop_x,
    input  logic signed [COORD_WIDTH-1:0] i_stop_y,
    output bbp_pkg::t_ctl                 o_ctl,
    output bbp_pkg::t_work                o_x,
    output bbp_pkg::t_work                o_y,
    output bbp_pkg::t_acc                 o_acc
);
    import bbp_pkg::*;

    localparam int DIFF_W   = COORD_WIDTH + 1;
    localparam int SCALE_SH = WORK_SHIFT - COORD_WIDTH;

    logic                     r_diff_valid;
    logic signed [DIFF_W-1:0] r_dx;
    logic signed [DIFF_W-1:0] r_dy;

    t_ctl  r_ctl;
    t_work r_x;
    t_work r_y;
    t_acc  r_acc;

    t_work n_x;
    t_work n_y;
    t_work sx;
    t_work sy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_diff_valid <= 1'b0;
        end else begin
            r_diff_valid <= i_valid;
        end
        r_dx <= DIFF_W'(i_stop_x) - DIFF_W'(i_start_x);
        r_dy <= DIFF_W'(i_stop_y) - DIFF_W'(i_start_y);
    end

    always_comb begin
        sx = t_work'({{(WORK_W-DIFF_W){r_dx[DIFF_W-1]}}, r_dx}) <<< SCALE_SH;
        sy = t_work'({{(WORK_W-DIFF_W){r_dy[DIFF_W-1]}}, r_dy}) <<< SCALE_SH;
        if (sy[WORK_W-1]) begin
            n_x = -sy;
            n_y = -sx;
        end else begin
            n_x = sy;
            n_y = sx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.valid <= 1'b0;
        end else begin
            r_ctl.valid <= r_diff_valid;
        end
        r_ctl.zero <= (r_dx == '0) && (r_dy == '0);
        r_x        <= n_x;
        r_y        <= n_y;
        r_acc      <= sy[WORK_W-1] ? HALF_TURN : '0;
    end

    assign o_ctl = r_ctl;
    assign o_x   = r_x;
    assign o_y   = r_y;
    assign o_acc = r_acc;

endmodule

// ===== hw/rtl/bbp_cell.sv =====
// One CORDIC vectoring micro-rotation with its pipeline register.
module bbp_cell #(
    parameter int STAGE = 0
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  bbp_pkg::t_ctl  i_ctl,
    input  bbp_pkg::t_work i_x,
    input  bbp_pkg::t_work i_y,
    input  bbp_pkg::t_acc  i_acc,
    output bbp_pkg::t_ctl  o_ctl,
    output bbp_pkg::t_work o_x,
    output bbp_pkg::t_work o_y,
    output bbp_pkg::t_acc  o_acc
);
    import bbp_pkg::*;

    localparam t_acc ANGLE = ATAN_TURNS[STAGE];

    t_ctl  r_ctl;
    t_work r_x;
    t_work r_y;
    t_acc  r_acc;

    t_work xs;
    t_work ys;

    assign xs = i_x >>> STAGE;
    assign ys = i_y >>> STAGE;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.valid <= 1'b0;
        end else begin
            r_ctl.valid <= i_ctl.valid;
        end
        r_ctl.zero <= i_ctl.zero;
        if (i_y[WORK_W-1]) begin
            r_x   <= i_x - ys;
            r_y   <= i_y + xs;
            r_acc <= i_acc - ANGLE;
        end else begin
            r_x   <= i_x + ys;
            r_y   <= i_y - xs;
            r_acc <= i_acc + ANGLE;
        end
    end

    assign o_ctl = r_ctl;
    assign o_x   = r_x;
    assign o_y   = r_y;
    assign o_acc = r_acc;

endmodule

// ===== hw/rtl/bearing_between_points.sv =====
// Top level of the bearing unit: front end, CORDIC cell chain and output rounding.
//
// A beat on the command channel carries a start point and a stop point in
// signed Q16.16. It is taken at a rising edge where start is high and busy
// is low. Busy is high only during reset and until the first rising edge
// that samples reset released, so a new point pair may be issued in every cycle.
// Each beat yields exactly one bearing, shown on o_bearing for one cycle
// with o_valid high once the beat has passed through the pipeline:
// two front-end stages, one stage per CORDIC cell, and the rounding stage.
// Throughput is one bearing per cycle; the pipeline depth is set by the
// cell chain, one micro-rotation per cell.
// The bearing is measured clockwise from +y as a fraction of a full turn.
// Equal points give a bearing of zero.
// The receiver cannot stall, so results are never held back or dropped.
// A synchronous reset clears every valid flag in the pipeline; points that
// were in flight are discarded.
module bearing_between_points #(
    parameter int COORD_WIDTH   = 32,
    parameter int ANGLE_WIDTH   = 16,
    parameter int CORDIC_STAGES = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [COORD_WIDTH-1:0] i_start_x,
    input  logic signed [COORD_WIDTH-1:0] i_start_y,
    input  logic signed [COORD_WIDTH-1:0] i_stop_x,
    input  logic signed [COORD_WIDTH-1:0] i_stop_y,
    output logic                          o_valid,
    output logic        [ANGLE_WIDTH-1:0] o_bearing
);
    import bbp_pkg::*;

    localparam int   HALF_SH = (ANGLE_WIDTH >= ACC_W) ? 0 : ACC_W - 1 - ANGLE_WIDTH;
    localparam t_acc HALF    = (ANGLE_WIDTH >= ACC_W) ? '0 : (t_acc'(1) << HALF_SH);

    logic r_ready;

    t_ctl  ctl_chain [0:CORDIC_STAGES];
    t_work x_chain   [0:CORDIC_STAGES];
    t_work y_chain   [0:CORDIC_STAGES];
    t_acc  acc_chain [0:CORDIC_STAGES];

    t_acc rounded;

    logic                   r_valid;
    logic [ANGLE_WIDTH-1:0] r_bearing;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready <= 1'b0;
        end else begin
            r_ready <= 1'b1;
        end
    end

    assign busy = !r_ready;

    bbp_prep #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_prep (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (start && !busy),
        .i_start_x(i_start_x),
        .i_start_y(i_start_y),
        .i_stop_x (i_stop_x),
        .i_stop_y (i_stop_y),
        .o_ctl    (ctl_chain[0]),
        .o_x      (x_chain[0]),
        .o_y      (y_chain[0]),
        .o_acc    (acc_chain[0])
    );

    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
        bbp_cell #(
            .STAGE(g)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_ctl  (ctl_chain[g]),
            .i_x    (x_chain[g]),
            .i_y    (y_chain[g]),
            .i_acc  (acc_chain[g]),
            .o_ctl  (ctl_chain[g+1]),
            .o_x    (x_chain[g+1]),
            .o_y    (y_chain[g+1]),
            .o_acc  (acc_chain[g+1])
        );
    end

    assign rounded = acc_chain[CORDIC_STAGES] + HALF;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= ctl_chain[CORDIC_STAGES].valid;
        end
        if (ctl_chain[CORDIC_STAGES].zero) begin
            r_bearing <= '0;
        end else begin
            r_bearing <= rounded[ACC_W-1 -: ANGLE_WIDTH];
        end
    end

    assign o_valid   = r_valid;
    assign o_bearing = r_bearing;

endmodule

// ===== verif/bearing_between_points_tb.sv =====
// Self-checking testbench for the CORDIC bearing unit, with its own fixed-point predictor.
module bearing_between_points_tb;

    typedef logic signed [31:0] t_coord;
    typedef logic [15:0]        t_bearing;
    typedef logic [31:0]        t_turn;

    typedef enum {
        PAIR_ANY,
        PAIR_NEAR,
        PAIR_SAME,
        PAIR_AXIS,
        PAIR_EXTREME,
        PAIR_DIAGONAL,
        PAIR_SCALED
    } t_pair_kind;

    localparam int     STAGES        = 16;
    localparam int     PIPE_LATENCY  = STAGES + 3;
    localparam int     SCALE_SHIFT   = 60 - 32;
    localparam int     RANDOM_PAIRS  = 450;
    localparam int     STALL_LIMIT   = 2000;
    localparam t_coord COORD_MAX     = 32'sh7FFF_FFFF;
    localparam t_coord COORD_MIN     = 32'sh8000_0000;
    localparam t_turn  TURN_HALF     = 32'h8000_0000;
    localparam t_turn  ROUND_HALF    = 32'h0000_8000;

    localparam t_turn ARCTAN_STEP [STAGES] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
    };

    logic     i_clk;
    logic     i_rst_n;
    logic     start;
    logic     busy;
    t_coord   i_start_x;
    t_coord   i_start_y;
    t_coord   i_stop_x;
    t_coord   i_stop_y;
    logic     o_valid;
    t_bearing o_bearing;

    t_bearing expected_bearings [$];
    int       pairs_accepted;
    int       bearings_checked;
    int       mismatches;
    int       quiet_cycles;

    bearing_between_points DUT (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .busy      (busy),
        .i_start_x (i_start_x),
        .i_start_y (i_start_y),
        .i_stop_x  (i_stop_x),
        .i_stop_y  (i_stop_y),
        .o_valid   (o_valid),
        .o_bearing (o_bearing)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_bearing predict_bearing(t_coord sx, t_coord sy, t_coord px, t_coord py);
        longint     dx;
        longint     dy;
        longint     vx;
        longint     vy;
        longint     vx_sh;
        longint     vy_sh;
        t_turn      angle;
        logic [32:0] rounded;
        dx = longint'(px) - longint'(sx);
        dy = longint'(py) - longint'(sy);
        if (dx == 0 && dy == 0) begin
            return '0;
        end
        vx = dy <<< SCALE_SHIFT;
        vy = dx <<< SCALE_SHIFT;
        angle = '0;
        if (vx < 0) begin
            vx = -vx;
            vy = -vy;
            angle = TURN_HALF;
        end
        for (int i = 0; i < STAGES; i++) begin
            vx_sh = vx >>> i;
            vy_sh = vy >>> i;
            if (vy < 0) begin
                vx = vx - vy_sh;
                vy = vy + vx_sh;
                angle = angle - ARCTAN_STEP[i];
            end else begin
                vx = vx + vy_sh;
                vy = vy - vx_sh;
                angle = angle + ARCTAN_STEP[i];
            end
        end
        rounded = {1'b0, angle} + {1'b0, ROUND_HALF};
        return rounded[31:16];
    endfunction

    function automatic t_coord pick_extreme();
        case ($urandom_range(0, 5))
            0: return COORD_MAX;
            1: return COORD_MIN;
            2: return 32'sd0;
            3: return -32'sd1;
            4: return 32'sd1;
            default: return COORD_MIN + 32'sd1;
        endcase
    endfunction

    // Input beats are taken and results are checked in one process, so the
    // order of check and push is fixed: the check comes first.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (expected_bearings.size() == 0) begin
                $display("%0t: unexpected bearing beat, actual %h", $time, o_bearing);
                mismatches++;
            end else begin
                bearings_checked++;
                if (o_bearing !== expected_bearings[0]) begin
                    $display("%0t: bearing mismatch, expected %h, actual %h",
                             $time, expected_bearings[0], o_bearing);
                    mismatches++;
                end
                void'(expected_bearings.pop_front());
            end
        end
        if (i_rst_n && start && !busy) begin
            expected_bearings.push_back(predict_bearing(i_start_x, i_start_y, i_stop_x, i_stop_y));
            pairs_accepted++;
        end
    end

    always @(posedge i_clk) begin
        if ((i_rst_n && start && !busy) || (i_rst_n && o_valid)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
            $display("%0t: no beat accepted for %0d cycles", $time, STALL_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_pair(input t_coord sx, input t_coord sy, input t_coord px,
                             input t_coord py);
        @(negedge i_clk);
        start     <= 1'b1;
        i_start_x <= sx;
        i_start_y <= sy;
        i_stop_x  <= px;
        i_stop_y  <= py;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic hold_off(input int cycles);
        if (cycles > 0) begin
            @(negedge i_clk);
            start     <= 1'b0;
            i_start_x <= $urandom;
            i_start_y <= $urandom;
            i_stop_x  <= $urandom;
            i_stop_y  <= $urandom;
            repeat (cycles - 1) @(negedge i_clk);
        end
    endtask

    task automatic test_equal_points();
        send_pair(32'sd0, 32'sd0, 32'sd0, 32'sd0);
        send_pair(COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN);
        send_pair(-32'sd1, COORD_MAX, -32'sd1, COORD_MAX);
    endtask

    task automatic test_compass_points();
        send_pair(32'sd0, 32'sd0, 32'sd0, 32'sd1);
        send_pair(32'sd0, 32'sd0, 32'sd1, 32'sd0);
        send_pair(32'sd0, 32'sd0, 32'sd0, -32'sd1);
        send_pair(32'sd0, 32'sd0, -32'sd1, 32'sd0);
        send_pair(32'sd100, 32'sd100, 32'sd200, 32'sd200);
        send_pair(32'sd100, 32'sd100, 32'sd200, 32'sd0);
        send_pair(32'sd100, 32'sd100, 32'sd0, 32'sd0);
        send_pair(32'sd100, 32'sd100, 32'sd0, 32'sd200);
    endtask

    task automatic test_coordinate_extremes();
        send_pair(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
        send_pair(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN);
        send_pair(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX);
        send_pair(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN);
        send_pair(32'sd0, 32'sd0, COORD_MAX, COORD_MIN);
        send_pair(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX - 32'sd1);
    endtask

    // The first pair gives a bearing just short of a full turn, which rounds up and must wrap to zero.
    task automatic test_rounding_wrap();
        send_pair(32'sd0, 32'sd0, -32'sd1, COORD_MAX);
        send_pair(COORD_MIN, COORD_MIN, COORD_MIN - 32'sd1, COORD_MAX);
        send_pair(32'sd0, 32'sd0, 32'sd1, COORD_MAX);
        send_pair(32'sd0, 32'sd0, -32'sd1, COORD_MIN);
    endtask

    task automatic test_random_tracks(input int count);
        int         sent;
        int         burst;
        int         roll;
        t_pair_kind kind;
        t_coord     sx;
        t_coord     sy;
        t_coord     px;
        t_coord     py;
        t_coord     step;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(1, 24);
            while (burst > 0 && sent < count) begin
                roll = $urandom_range(0, 99);
                kind = roll < 30 ? PAIR_ANY : roll < 50 ? PAIR_NEAR : roll < 58 ? PAIR_SAME :
                       roll < 68 ? PAIR_AXIS : roll < 78 ? PAIR_EXTREME :
                       roll < 86 ? PAIR_DIAGONAL : PAIR_SCALED;
                sx = $urandom;
                sy = $urandom;
                px = $urandom;
                py = $urandom;
                case (kind)
                    PAIR_NEAR: begin
                        px = sx + $signed($urandom_range(0, 8191)) - 32'sd4096;
                        py = sy + $signed($urandom_range(0, 8191)) - 32'sd4096;
                    end
                    PAIR_SAME: begin
                        px = sx;
                        py = sy;
                    end
                    PAIR_AXIS: begin
                        if ($urandom_range(0, 1)) px = sx;
                        else py = sy;
                    end
                    PAIR_EXTREME: begin
                        sx = pick_extreme();
                        sy = pick_extreme();
                        px = pick_extreme();
                        py = pick_extreme();
                    end
                    PAIR_DIAGONAL: begin
                        step = $urandom_range(1, 1 << 20);
                        px = $urandom_range(0, 1) ? sx + step : sx - step;
                        py = $urandom_range(0, 1) ? sy + step : sy - step;
                    end
                    PAIR_SCALED: begin
                        px = sx + (t_coord'($urandom) >>> $urandom_range(0, 31));
                        py = sy + (t_coord'($urandom) >>> $urandom_range(0, 31));
                    end
                    default: begin
                    end
                endcase
                send_pair(sx, sy, px, py);
                sent++;
                burst--;
            end
            hold_off($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 28));
        end
    endtask

    initial begin
        i_rst_n          = 1'b0;
        start            = 1'b0;
        i_start_x        = '0;
        i_start_y        = '0;
        i_stop_x         = '0;
        i_stop_y         = '0;
        quiet_cycles     = 0;
        pairs_accepted   = 0;
        bearings_checked = 0;
        mismatches       = 0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_equal_points();
        hold_off($urandom_range(1, 25));
        test_compass_points();
        hold_off($urandom_range(1, 25));
        test_coordinate_extremes();
        test_rounding_wrap();
        hold_off($urandom_range(1, 25));
        test_random_tracks(RANDOM_PAIRS);
        hold_off(1);

        while (expected_bearings.size() != 0) @(posedge i_clk);
        repeat (PIPE_LATENCY + 4) @(posedge i_clk);

        $display("Run covered %0d point pairs: equal points, compass and diagonal bearings,",
                 pairs_accepted);
        $display("coordinate extremes, wrap at a full turn and random tracks; %0d bearings compared.",
                 bearings_checked);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/bbp_pkg.sv
hw/rtl/bbp_prep.sv
hw/rtl/bbp_cell.sv
hw/rtl/bearing_between_points.sv
verif/bearing_between_points_tb.sv
